// ----- rtl/qpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// qpfd_pkg
// Shared types and constants for the quantized pose frame decoder.
// ----------------------------------------------------------------------------
package qpfd_pkg;

    localparam int SCALAR_DEPTH   = 256;
    localparam int ROTATION_DEPTH = 256;
    localparam int SCALAR_AW      = $clog2(SCALAR_DEPTH);
    localparam int ROTATION_AW    = $clog2(ROTATION_DEPTH);

    localparam logic [1:0] ACT_LOAD_SCALAR   = 2'd0;
    localparam logic [1:0] ACT_LOAD_ROTATION = 2'd1;
    localparam logic [1:0] ACT_FRAME         = 2'd2;

    localparam logic [1:0] REG_BIG_ENDIAN     = 2'd0;
    localparam logic [1:0] REG_SCALAR_COUNT   = 2'd1;
    localparam logic [1:0] REG_ROTATION_COUNT = 2'd2;
    localparam logic [1:0] REG_TRACK_COUNT    = 2'd3;

    localparam logic [1:0] KIND_TRANSLATION = 2'd0;
    localparam logic [1:0] KIND_SCALE       = 2'd1;
    localparam logic [1:0] KIND_ROTATION    = 2'd2;

    // round(0.000043161 * 2^32)
    localparam logic [17:0] QSCALE = 18'd185375;

    typedef struct packed {
        logic [15:0]        code;
        logic signed [31:0] minimum;
        logic signed [31:0] span;
    } sc_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SC_ABS,
        ST_SC_EST,
        ST_SC_REM,
        ST_SC_FIX,
        ST_Q_MUL,
        ST_Q_SQ,
        ST_Q_RAD,
        ST_SQRT,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/qpfd_tables.sv -----
// ----------------------------------------------------------------------------
// qpfd_tables
// Scalar and rotation tables, one write and one registered read port each.
// ----------------------------------------------------------------------------
module qpfd_tables
    import qpfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   sc_we,
    input  logic [SCALAR_AW-1:0]   sc_waddr,
    input  sc_entry_t              sc_wdata,
    input  logic                   rot_we,
    input  logic [ROTATION_AW-1:0] rot_waddr,
    input  logic [15:0]            rot_wdata,
    input  logic                   rd_en,
    input  logic [SCALAR_AW-1:0]   sc_raddr,
    input  logic [ROTATION_AW-1:0] rot_raddr,
    output sc_entry_t              sc_rdata,
    output logic [15:0]            rot_rdata
);

    sc_entry_t   sc_mem  [SCALAR_DEPTH];
    logic [15:0] rot_mem [ROTATION_DEPTH];

    always_ff @(posedge aclk) begin
        if (sc_we) begin
            sc_mem[sc_waddr] <= sc_wdata;
        end
        if (rd_en) begin
            sc_rdata <= sc_mem[sc_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rot_we) begin
            rot_mem[rot_waddr] <= rot_wdata;
        end
        if (rd_en) begin
            rot_rdata <= rot_mem[rot_raddr];
        end
    end

endmodule

// ----- rtl/qpfd_isqrt.sv -----
// ----------------------------------------------------------------------------
// qpfd_isqrt
// Iterative square root of a 33-bit value, rounded to nearest.
// ----------------------------------------------------------------------------
module qpfd_isqrt
    import qpfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] value,
    output logic        done,
    output logic [16:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_reg;
    logic [33:0] res_reg;
    logic [32:0] bit_reg;
    logic [16:0] root_reg;
    logic [33:0] trial;

    assign trial = res_reg + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= value;
            res_reg <= '0;
            bit_reg <= 33'h1_0000_0000;
        end else if (busy_reg) begin
            if (bit_reg == '0) begin
                root_reg <= ({1'b0, rem_reg} > res_reg) ? 17'(res_reg + 34'd1)
                                                         : res_reg[16:0];
            end else begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_reg <= 33'({1'b0, rem_reg} - trial);
                    res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/quantized_pose_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// quantized_pose_frame_decoder_top
// Table-driven decoder of quantized scalar and quaternion frame elements.
// ----------------------------------------------------------------------------
// Load items write the scalar or rotation table, produce no result and leave
// the decoder ready for the next item. A frame element reads its table entry
// from memory and then runs a sequencer. A scalar goes through a multiply,
// a divide by 65535 with up to three correction steps, and a saturating add
// before it reaches the output register. A quaternion runs three shared
// multiply steps, three square steps and, when the radicand is positive, the
// square root unit (17 steps plus rounding and handshake). One item is worked
// on at a time, and the next item is accepted once the result is written to
// the output register. A new item is taken while the previous result still
// waits in the output register.
module quantized_pose_frame_decoder_top
    import qpfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [7:0]         s_entry_index,
    input  logic [15:0]        s_element_code,
    input  logic signed [31:0] s_range_min,
    input  logic signed [31:0] s_range_span,
    input  logic [47:0]        s_raw_bits,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_applied,
    output logic [1:0]         m_kind,
    output logic [9:0]         m_track,
    output logic [1:0]         m_component,
    output logic signed [31:0] m_value_a,
    output logic signed [31:0] m_value_b,
    output logic signed [31:0] m_value_c,
    output logic signed [31:0] m_value_d,
    output logic               m_last_of_frame
);

    state_t state_reg, state_next;

    logic       big_endian_reg;
    logic [8:0] scalar_count_reg;
    logic [8:0] rotation_count_reg;
    logic [9:0] track_count_reg;
    logic [8:0] frame_pos_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg     <= 1'b0;
            scalar_count_reg   <= '0;
            rotation_count_reg <= '0;
            track_count_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BIG_ENDIAN:     big_endian_reg     <= cfg_wdata[0];
                REG_SCALAR_COUNT:   scalar_count_reg   <= cfg_wdata[8:0];
                REG_ROTATION_COUNT: rotation_count_reg <= cfg_wdata[8:0];
                REG_TRACK_COUNT:    track_count_reg    <= cfg_wdata;
            endcase
        end
    end

    // frame position
    logic [8:0] sc_cnt, rc_cnt, pos, rot_idx;
    logic [9:0] total;
    logic       pos_last, pos_scalar, s_accept, frame_go;
    logic [15:0] w_in [3];

    assign sc_cnt = (scalar_count_reg > 9'(SCALAR_DEPTH)) ? 9'(SCALAR_DEPTH)
                                                          : scalar_count_reg;
    assign rc_cnt = (rotation_count_reg > 9'(ROTATION_DEPTH)) ? 9'(ROTATION_DEPTH)
                                                              : rotation_count_reg;
    assign total      = {1'b0, sc_cnt} + {1'b0, rc_cnt};
    assign pos        = ({1'b0, frame_pos_reg} >= total) ? '0 : frame_pos_reg;
    assign pos_last   = ({1'b0, pos} == total - 10'd1);
    assign pos_scalar = (pos < sc_cnt);
    assign rot_idx    = pos - sc_cnt;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign frame_go   = s_accept && s_action == ACT_FRAME && total != '0;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_in[k] = big_endian_reg ? {s_raw_bits[16*k +: 8], s_raw_bits[16*k+8 +: 8]}
                                     : s_raw_bits[16*k +: 16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg <= '0;
        end else if (s_accept && s_action == ACT_FRAME) begin
            if (total == '0 || pos_last) begin
                frame_pos_reg <= '0;
            end else begin
                frame_pos_reg <= pos + 9'd1;
            end
        end
    end

    // tables
    sc_entry_t   sc_wdata, sc_rdata;
    logic [15:0] rot_rdata;
    logic        sc_we, rot_we;

    assign sc_wdata = '{code: s_element_code, minimum: s_range_min, span: s_range_span};
    assign sc_we    = s_accept && s_action == ACT_LOAD_SCALAR
                      && {1'b0, s_entry_index} < 9'(SCALAR_DEPTH);
    assign rot_we   = s_accept && s_action == ACT_LOAD_ROTATION
                      && {1'b0, s_entry_index} < 9'(ROTATION_DEPTH);

    qpfd_tables u_tables (
        .aclk      (aclk),
        .sc_we     (sc_we),
        .sc_waddr  (s_entry_index[SCALAR_AW-1:0]),
        .sc_wdata  (sc_wdata),
        .rot_we    (rot_we),
        .rot_waddr (s_entry_index[ROTATION_AW-1:0]),
        .rot_wdata (s_element_code),
        .rd_en     (frame_go),
        .sc_raddr  (pos[SCALAR_AW-1:0]),
        .rot_raddr (rot_idx[ROTATION_AW-1:0]),
        .sc_rdata  (sc_rdata),
        .rot_rdata (rot_rdata)
    );

    // datapath registers
    logic               is_scalar_reg, last_reg;
    logic [15:0]        w_reg [3];
    logic [14:0]        t_reg;
    logic [3:0]         m_reg;
    logic signed [48:0] prod_reg;
    logic               neg_reg;
    logic [48:0]        y_reg;
    logic [32:0]        q_reg;
    logic [17:0]        r_reg;
    logic [1:0]         k_reg;
    logic signed [17:0] comp_reg [3];
    logic [35:0]        sum_reg;
    logic               rad_pos_reg;

    // read-stage combinational values
    logic [15:0]        code;
    logic [30:0]        t12_prod;
    logic [33:0]        t3_prod;
    logic [12:0]        t12;
    logic [15:0]        m_full;

    assign code     = is_scalar_reg ? sc_rdata.code : rot_rdata;
    assign t12_prod = {3'b0, code[15:2]} * 17'd43691;
    assign t12      = t12_prod[29:17];
    assign t3_prod  = code * 18'd87382;
    assign m_full   = code - ({t12, 3'b0} + {1'b0, t12, 2'b0});

    // quaternion component
    logic signed [16:0] q_n;
    logic signed [35:0] q_p;
    logic [35:0]        q_mag;
    logic [35:0]        q_rnd;
    logic signed [17:0] q_comp;
    logic signed [35:0] comp_sq;

    assign q_n    = $signed({2'b0, w_reg[k_reg][14:0]}) - 17'sd16383;
    assign q_p    = q_n * $signed({1'b0, QSCALE});
    assign q_mag  = q_p[35] ? 36'(-q_p) : q_p;
    assign q_rnd  = (q_mag + 36'd32768) >> 16;
    assign q_comp = q_p[35] ? 18'(-$signed(q_rnd[17:0])) : $signed(q_rnd[17:0]);
    assign comp_sq = comp_reg[k_reg] * comp_reg[k_reg];

    logic signed [36:0] rad_full;
    assign rad_full = 37'sh1_0000_0000 - $signed({1'b0, sum_reg});

    logic        sqrt_start, sqrt_done;
    logic [16:0] sqrt_root;

    qpfd_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (rad_full[32:0]),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (frame_go) begin
            is_scalar_reg <= pos_scalar;
            last_reg      <= pos_last;
            for (int k = 0; k < 3; k++) begin
                w_reg[k] <= w_in[k];
            end
        end
        unique case (state_reg)
            ST_READ: begin
                t_reg    <= is_scalar_reg ? {2'b0, t12} : t3_prod[32:18];
                m_reg    <= m_full[3:0];
                prod_reg <= $signed({sc_rdata.span[31], sc_rdata.span})
                            * $signed({1'b0, w_reg[0]});
                k_reg    <= '0;
                sum_reg  <= '0;
            end
            ST_SC_ABS: begin
                neg_reg <= prod_reg[48];
                y_reg   <= (prod_reg[48] ? 49'(-prod_reg) : prod_reg) + 49'd32767;
            end
            ST_SC_EST: q_reg <= 33'((y_reg >> 16) + (y_reg >> 32));
            ST_SC_REM: r_reg <= 18'(y_reg - {q_reg, 16'b0} + {16'b0, q_reg});
            ST_SC_FIX: begin
                if (r_reg >= 18'd65535) begin
                    r_reg <= r_reg - 18'd65535;
                    q_reg <= q_reg + 33'd1;
                end
            end
            ST_Q_MUL: begin
                comp_reg[k_reg] <= q_comp;
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end
            ST_Q_SQ: begin
                sum_reg <= sum_reg + $unsigned(comp_sq);
                k_reg <= k_reg + 2'd1;
            end
            ST_Q_RAD: begin
                rad_pos_reg <= rad_full > 37'sd0;
            end
            default: begin
            end
        endcase
    end

    // next state
    logic out_free;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (frame_go) state_next = ST_READ;
            ST_READ:   state_next = is_scalar_reg ? ST_SC_ABS : ST_Q_MUL;
            ST_SC_ABS: state_next = ST_SC_EST;
            ST_SC_EST: state_next = ST_SC_REM;
            ST_SC_REM: state_next = ST_SC_FIX;
            ST_SC_FIX: if (r_reg < 18'd65535) state_next = ST_EMIT;
            ST_Q_MUL:  if (k_reg == 2'd2) state_next = ST_Q_SQ;
            ST_Q_SQ:   if (k_reg == 2'd2) state_next = ST_Q_RAD;
            ST_Q_RAD:  state_next = (rad_full > 37'sd0) ? ST_SQRT : ST_EMIT;
            ST_SQRT:   if (sqrt_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    logic emit;
    always_comb begin
        sqrt_start = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_Q_RAD: sqrt_start = rad_full > 37'sd0;
            ST_EMIT:  emit       = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // result assembly
    logic signed [33:0] sq_signed;
    logic signed [34:0] sc_sum;
    logic signed [31:0] sc_val, w_val;
    logic [1:0]         sel;
    logic               track_ok;
    logic [9:0]         track_sat;

    assign sq_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign sc_sum    = 35'(sc_rdata.minimum) + 35'(sq_signed);
    assign sc_val    = (sc_sum > 35'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                       (sc_sum < -35'sh0_8000_0000) ? 32'sh8000_0000 : sc_sum[31:0];
    assign w_val     = !rad_pos_reg ? 32'sd0 :
                       w_reg[2][15] ? -$signed({15'b0, sqrt_root})
                                    : $signed({15'b0, sqrt_root});
    assign sel       = {w_reg[1][15], w_reg[0][15]};
    assign track_ok  = t_reg < {5'b0, track_count_reg};
    assign track_sat = (t_reg > 15'd1023) ? 10'd1023 : t_reg[9:0];

    logic               m_valid_reg;
    logic               applied_reg, last_out_reg;
    logic [1:0]         kind_reg, comp_out_reg;
    logic [9:0]         track_reg;
    logic signed [31:0] va_reg, vb_reg, vc_reg, vd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            track_reg    <= track_sat;
            last_out_reg <= last_reg;
            if (is_scalar_reg) begin
                va_reg <= sc_val;
                vb_reg <= '0;
                vc_reg <= '0;
                vd_reg <= '0;
                if (m_reg <= 4'd2) begin
                    applied_reg  <= track_ok;
                    kind_reg     <= KIND_TRANSLATION;
                    comp_out_reg <= m_reg[1:0];
                end else if (m_reg >= 4'd8 && m_reg <= 4'd10) begin
                    applied_reg  <= track_ok;
                    kind_reg     <= KIND_SCALE;
                    comp_out_reg <= 2'(m_reg - 4'd8);
                end else begin
                    applied_reg  <= 1'b0;
                    kind_reg     <= KIND_TRANSLATION;
                    comp_out_reg <= '0;
                end
            end else begin
                applied_reg  <= track_ok;
                kind_reg     <= KIND_ROTATION;
                comp_out_reg <= '0;
                unique case (sel)
                    2'd0: begin
                        va_reg <= w_val;       vb_reg <= 32'(comp_reg[0]);
                        vc_reg <= 32'(comp_reg[1]); vd_reg <= 32'(comp_reg[2]);
                    end
                    2'd1: begin
                        va_reg <= 32'(comp_reg[0]); vb_reg <= w_val;
                        vc_reg <= 32'(comp_reg[1]); vd_reg <= 32'(comp_reg[2]);
                    end
                    2'd2: begin
                        va_reg <= 32'(comp_reg[0]); vb_reg <= 32'(comp_reg[1]);
                        vc_reg <= w_val;       vd_reg <= 32'(comp_reg[2]);
                    end
                    2'd3: begin
                        va_reg <= 32'(comp_reg[0]); vb_reg <= 32'(comp_reg[1]);
                        vc_reg <= 32'(comp_reg[2]); vd_reg <= w_val;
                    end
                endcase
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_applied       = applied_reg;
    assign m_kind          = kind_reg;
    assign m_track         = track_reg;
    assign m_component     = comp_out_reg;
    assign m_value_a       = va_reg;
    assign m_value_b       = vb_reg;
    assign m_value_c       = vc_reg;
    assign m_value_d       = vd_reg;
    assign m_last_of_frame = last_out_reg;

endmodule
